[sv/msrt_pkg.sv]
// Shared types, constants and CRC helper for the Modbus sensor read block.
package msrt_pkg;

   // Request kinds on the input channel
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_BYTE  = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 1'b1;
   localparam int unsigned CSR_DATA_W = 16;

   // Configuration reset values
   localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'd1;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

   // Request frame contents
   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [15:0] START_REGISTER    = 16'h0000;
   localparam logic [15:0] REGISTER_COUNT    = 16'h0002;

   // CRC-16 (reflected)
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Output item kinds
   localparam logic KIND_TX_BYTE = 1'b0;
   localparam logic KIND_RESULT  = 1'b1;

   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 48;

   // Work handed from the core to the output sequencer
   typedef struct packed {
      logic               frame;       // 1: emit the 8-byte request, 0: emit one result
      logic [7:0]         slave_addr;
      logic               ok;
      logic [15:0]        humidity;
      logic signed [15:0] temperature;
   } msrt_desc_type;

   // One byte through the CRC-16 shift register
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[sv/msrt_core.sv]
// Input register, transaction state and reply checking for one item per cycle, unless an output item stalls.
module msrt_core
   import msrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output msrt_desc_type         desc,
   output logic                  desc_valid,
   input  logic                  desc_ready
);

   localparam logic PHASE_IDLE    = 1'b0;
   localparam logic PHASE_COLLECT = 1'b1;

   logic        in_valid_ff;
   logic [1:0]  in_type_ff;
   logic [7:0]  in_byte_ff;

   logic [7:0]  slave_addr_ff;
   logic [15:0] timeout_ff;

   logic        phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  reply_ff [5];

   logic        emit;
   logic        advance;
   logic        wr_en;
   logic [2:0]  wr_idx;
   logic [3:0]  count_off;
   logic [15:0] elapsed_inc;
   logic [15:0] rx_crc;
   logic        crc_match;
   msrt_desc_type desc_in;

   assign count_off   = count_ff - 4'd3;
   assign elapsed_inc = elapsed_ff + 16'd1;
   assign rx_crc      = {in_byte_ff, reply_ff[4]};
   assign crc_match   = (rx_crc == crc_ff);

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      elapsed_in = elapsed_ff;
      emit       = 1'b0;
      wr_en      = 1'b0;
      wr_idx     = 3'd0;
      desc_in.frame       = 1'b0;
      desc_in.slave_addr  = slave_addr_ff;
      desc_in.ok          = 1'b0;
      desc_in.humidity    = 16'd0;
      desc_in.temperature = 16'sd0;

      priority if (in_type_ff == REQ_START) begin
         emit          = 1'b1;
         desc_in.frame = 1'b1;
         phase_in      = PHASE_COLLECT;
         count_in      = 4'd0;
         crc_in        = CRC_INIT;
         elapsed_in    = 16'd0;
      end else if (phase_ff == PHASE_COLLECT && in_type_ff == REQ_BYTE) begin
         priority if (count_ff < 4'd7) begin
            crc_in   = crc_byte(crc_ff, in_byte_ff);
            count_in = count_ff + 4'd1;
            if (count_ff >= 4'd3) begin
               wr_en  = 1'b1;
               wr_idx = count_off[2:0];
            end
         end else if (count_ff == 4'd7) begin
            // low CRC byte of the reply
            wr_en    = 1'b1;
            wr_idx   = 3'd4;
            count_in = 4'd8;
         end else begin
            emit       = 1'b1;
            desc_in.ok = crc_match;
            if (crc_match) begin
               desc_in.humidity    = {reply_ff[1], reply_ff[0]};
               desc_in.temperature = {reply_ff[3], reply_ff[2]};
            end
            phase_in   = PHASE_IDLE;
            count_in   = 4'd0;
            crc_in     = CRC_INIT;
            elapsed_in = 16'd0;
         end
      end else if (phase_ff == PHASE_COLLECT && in_type_ff == REQ_TICK) begin
         elapsed_in = elapsed_inc;
         if (elapsed_inc >= timeout_ff || elapsed_inc == 16'd0) begin
            emit       = 1'b1;
            phase_in   = PHASE_IDLE;
            count_in   = 4'd0;
            crc_in     = CRC_INIT;
            elapsed_in = 16'd0;
         end
      end else begin
         // idle bytes, idle ticks and unused codes drop out here
         emit = 1'b0;
      end
   end

   assign desc       = desc_in;
   assign desc_valid = in_valid_ff & emit;
   assign advance    = in_valid_ff & (~emit | desc_ready);
   assign req_tready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         slave_addr_ff <= SLAVE_ADDRESS_RESET;
         timeout_ff    <= TIMEOUT_TICKS_RESET;
         phase_ff      <= PHASE_IDLE;
         count_ff      <= 4'd0;
         crc_ff        <= CRC_INIT;
         elapsed_ff    <= 16'd0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_SLAVE_ADDRESS: slave_addr_ff <= csr_wdata[7:0];
               CSR_TIMEOUT_TICKS: timeout_ff    <= csr_wdata;
               default:           timeout_ff    <= timeout_ff;
            endcase
         end
         if (advance) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            crc_ff     <= crc_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_type_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (advance && wr_en) begin
         reply_ff[wr_idx] <= in_byte_ff;
      end
   end

endmodule

[sv/msrt_tx.sv]
// Output register and sequencer that plays out request frames and results.
module msrt_tx
   import msrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  msrt_desc_type         desc,
   input  logic                  desc_valid,
   output logic                  desc_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic               valid_ff;
   logic               frame_ff;
   logic [2:0]         beat_ff;
   logic [15:0]        crc_ff;
   logic [7:0]         addr_ff;
   logic               ok_ff;
   logic [15:0]        hum_ff;
   logic signed [15:0] temp_ff;

   logic [7:0] cur_byte;
   logic       last_beat;
   logic       fire;
   logic       load;

   always_comb begin
      unique case (beat_ff)
         3'd0:    cur_byte = addr_ff;
         3'd1:    cur_byte = FUNC_READ_HOLDING;
         3'd2:    cur_byte = START_REGISTER[15:8];
         3'd3:    cur_byte = START_REGISTER[7:0];
         3'd4:    cur_byte = REGISTER_COUNT[15:8];
         3'd5:    cur_byte = REGISTER_COUNT[7:0];
         3'd6:    cur_byte = crc_ff[7:0];
         default: cur_byte = crc_ff[15:8];
      endcase
   end

   assign last_beat  = ~frame_ff | (beat_ff == 3'd7);
   assign fire       = valid_ff & rsp_tready;
   assign desc_ready = ~valid_ff | (fire & last_beat);
   assign load       = desc_valid & desc_ready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = frame_ff & (beat_ff == 3'd7);
   assign rsp_tuser  = frame_ff ? KIND_TX_BYTE : KIND_RESULT;
   assign rsp_tdata  = {7'd0, temp_ff, hum_ff, ~frame_ff & ok_ff,
                        frame_ff ? cur_byte : 8'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (fire && last_beat) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= desc.frame;
         beat_ff  <= 3'd0;
         crc_ff   <= CRC_INIT;
         addr_ff  <= desc.slave_addr;
         ok_ff    <= desc.ok;
         hum_ff   <= desc.humidity;
         temp_ff  <= desc.temperature;
      end else if (fire && !last_beat) begin
         beat_ff <= beat_ff + 3'd1;
         // hold the CRC once the six header bytes are through
         if (beat_ff < 3'd6) begin
            crc_ff <= crc_byte(crc_ff, cur_byte);
         end
      end
   end

endmodule

[sv/modbus_sensor_read_transaction.sv]
// Top level of the Modbus RTU master that reads one temperature/humidity sensor.
//
//   channel  direction  handshake              payload
//   req_     in         req_tvalid/req_tready  tuser: kind, tdata: received byte
//   rsp_     out        rsp_tvalid/rsp_tready  tuser: kind, tlast: frame end,
//                                              tdata: byte, ok, humidity, temp
//   csr_     in         csr_we                 csr_index, csr_wdata
//
// Items pass the input register, and results the output register, before rsp_.
// Bytes and ticks flow one per cycle; one ending a transaction waits while the
// sequencer is busy. A start item plays out eight request bytes, one per cycle
// while rsp_tready is high, and holds the input side while a further result
// would wait. Synchronous reset clears control state; rsp_ stalls hold output.
module modbus_sensor_read_transaction
   import msrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // received item
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,   // [1:0] req_type
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   // result item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] tx_byte, [8] read_ok,
                                              // [24:9] humidity_tenths,
                                              // [40:25] temperature_tenths, [47:41] zero
   output logic                  rsp_tlast,   // tx_last
   output logic                  rsp_tuser,   // [0] out_kind
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   msrt_desc_type desc;
   logic          desc_valid;
   logic          desc_ready;

   // Track phase, reply bytes, running CRC and timeout; decide what to emit.
   msrt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .desc       (desc),
      .desc_valid (desc_valid),
      .desc_ready (desc_ready)
   );

   // Hold the pending output and advance through request bytes with their CRC.
   msrt_tx u_tx (
      .clock      (clock),
      .reset      (reset),
      .desc       (desc),
      .desc_valid (desc_valid),
      .desc_ready (desc_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
